// ===== rtl/core/tvm_pkg.sv =====
`timescale 1ns / 1ps

package tvm_pkg;

  localparam logic [15:0] PERIOD_MIN   = 16'd40;
  localparam logic [15:0] PERIOD_MAX   = 16'd50000;
  localparam logic [9:0]  FADE_START   = 10'd512;
  localparam logic [9:0]  PAN_SURR     = 10'd512;
  localparam logic [9:0]  PAN_CENTRE   = 10'd128;
  localparam logic [13:0] SVOL_MAX     = 14'h3FFF;
  localparam logic [15:0] MIXV_MAX     = 16'hFFFF;

  localparam logic [1:0] KICK_NEW  = 2'd1;
  localparam logic [1:0] KICK_OFF  = 2'd3;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_RAMPDN = 2'd2;
  localparam logic [1:0] WAVE_RAMPUP = 2'd3;

  // Operations of the shared multiplier, in issue order
  localparam logic [2:0] STEP_FADE_CHAN = 3'd0;
  localparam logic [2:0] STEP_NOTE      = 3'd1;
  localparam logic [2:0] STEP_MIX       = 3'd2;
  localparam logic [2:0] STEP_GLOBAL    = 3'd3;
  localparam logic [2:0] STEP_ENV       = 3'd4;
  localparam logic [2:0] STEP_PAN       = 3'd5;
  localparam logic [2:0] STEP_VIB       = 3'd6;

  typedef enum logic [3:0] {
    REG_VIB_DEPTH    = 4'd0,
    REG_VIB_SWEEP    = 4'd1,
    REG_VIB_RATE     = 4'd2,
    REG_VIB_WAVEFORM = 4'd3,
    REG_FADE_RATE    = 4'd4,
    REG_STEREO_ON    = 4'd5,
    REG_MIX_LEVEL    = 4'd6,
    REG_GLOBAL_LEVEL = 4'd7
  } tvm_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } tvm_state_e;

  // Sine magnitude, 128 entries over half a period
  localparam logic [6:0] SINE_TAB [128] = '{
     7'd0,  7'd1,  7'd3,  7'd4,  7'd6,  7'd7,  7'd9, 7'd10,
    7'd12, 7'd14, 7'd15, 7'd17, 7'd18, 7'd20, 7'd21, 7'd23,
    7'd24, 7'd25, 7'd27, 7'd28, 7'd30, 7'd31, 7'd32, 7'd34,
    7'd35, 7'd36, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd44,
    7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52,
    7'd53, 7'd54, 7'd54, 7'd55, 7'd56, 7'd57, 7'd57, 7'd58,
    7'd59, 7'd59, 7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62,
    7'd62, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63,
    7'd64, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63,
    7'd62, 7'd62, 7'd62, 7'd61, 7'd61, 7'd60, 7'd60, 7'd59,
    7'd59, 7'd58, 7'd57, 7'd57, 7'd56, 7'd55, 7'd54, 7'd54,
    7'd53, 7'd52, 7'd51, 7'd50, 7'd49, 7'd48, 7'd47, 7'd46,
    7'd45, 7'd44, 7'd42, 7'd41, 7'd40, 7'd39, 7'd38, 7'd36,
    7'd35, 7'd34, 7'd32, 7'd31, 7'd30, 7'd28, 7'd27, 7'd25,
    7'd24, 7'd23, 7'd21, 7'd20, 7'd18, 7'd17, 7'd15, 7'd14,
    7'd12, 7'd10,  7'd9,  7'd7,  7'd6,  7'd4,  7'd3,  7'd1
  };

endpackage

// ===== rtl/core/tracker_voice_tick_modulator.sv =====
`timescale 1ns / 1ps

// Per-tick voice modulator: fadeout, auto-vibrato, volume and panning shaping.
// Input stream (s_axis): one transaction per voice per tracker tick; tuser
// carries the kick code, tdata the period, volume factors, envelope results
// and flags. Output stream (m_axis): one result transaction per input, with
// tuser = dead and tdata = volumes, panning and vibrated period.
// Config channel (cfg_*): register index and data, always ready; write it
// only while no transaction is in flight.
// An item is captured at the accepting edge; then seven passes go through
// the single shared 44x10 multiplier (five volume factors, the panning
// span, the vibrato depth), and the result is loaded into the output
// register. s_axis_tready is low from acceptance until that load, so the
// block takes no new item before it is through with the last one.
// The result sits in an output register; the next item may be accepted
// while it waits. If the receiver stalls, the following result holds in
// the sequencer until the output register frees up.
// Reset (rst_ni low) clears the fade level, vibrato phase and sweep, the
// sequencer and the output valid, and loads the register reset values.
module tracker_voice_tick_modulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] period_in, [22:16] chan_volume, [31:23] note_volume,
  // [38:32] vol_env_level, [39] vol_env_done, [40] vol_env_zero_end,
  // [50:41] pan_position, [57:51] pan_env_level, [58] note_fading,
  // [59] muted, [60] voice_gone, [63:61] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] kick
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] mix_volume, [29:16] sample_volume, [39:30] pan_out,
  // [56:40] period_out, [63:57] zero
  output logic [63:0] m_axis_tdata,
  // [0] dead
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [10:0] cfg_data_i
);
  import tvm_pkg::*;

  // Configuration registers
  logic [7:0]  vib_depth_q, vib_sweep_speed_q, vib_rate_q;
  logic [1:0]  vib_waveform_q;
  logic [10:0] fade_rate_q;
  logic        stereo_on_q;
  logic [7:0]  mix_level_q, global_level_q;

  // Voice state
  logic [9:0]  fade_level_q, fade_level_d;
  logic [7:0]  vib_phase_q;
  logic [15:0] vib_sweep_q, vib_sweep_d;

  tvm_state_e  state_q, state_d;
  logic [2:0]  step_q;

  // Captured item
  logic [9:0]  fade_cur_q;
  logic [6:0]  chan_q, venv_q;
  logic [8:0]  notev_q;
  logic [9:0]  pan_pos_q;
  logic [6:0]  pan_env_q;
  logic [15:0] period_q;
  logic        muted_q, dead_q;
  logic [15:0] depth_t_q;
  logic [7:0]  wave_q;

  // Work results
  logic [48:0] acc_q;
  logic [13:0] svol_q;
  logic [15:0] mixv_q;
  logic [17:0] pan_mul_q;
  logic [7:0]  vib_off_q;

  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic        m_dead_q;

  // Input field unpacking
  logic [1:0]  in_kick;
  logic [15:0] in_period;
  logic [6:0]  in_chan, in_venv, in_pan_env;
  logic [8:0]  in_notev;
  logic        in_done, in_zero, in_fading, in_muted, in_gone;
  logic [9:0]  in_pan_pos;

  assign in_kick    = s_axis_tuser;
  assign in_period  = s_axis_tdata[15:0];
  assign in_chan    = s_axis_tdata[22:16];
  assign in_notev   = s_axis_tdata[31:23];
  assign in_venv    = s_axis_tdata[38:32];
  assign in_done    = s_axis_tdata[39];
  assign in_zero    = s_axis_tdata[40];
  assign in_pan_pos = s_axis_tdata[50:41];
  assign in_pan_env = s_axis_tdata[57:51];
  assign in_fading  = s_axis_tdata[58];
  assign in_muted   = s_axis_tdata[59];
  assign in_gone    = s_axis_tdata[60];

  logic in_fire;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Capture-time logic: kick, envelope end, fade step, period clamp, sweep and waveform
  logic [9:0]  fade_kick, fade_cur;
  logic        fading_eff;
  logic [15:0] period_clamp;
  logic        sweep_grow;
  logic [15:0] sweep_sum, depth_t;
  logic [15:0] sweep_base;
  logic [6:0]  ramp;
  logic [7:0]  sine_mag, wave;

  always_comb begin
    fade_kick  = ((in_kick == KICK_NEW) || (in_kick == KICK_OFF)) ? FADE_START
                                                                 : fade_level_q;
    fade_cur   = (in_done && in_zero) ? 10'd0 : fade_kick;
    fading_eff = in_fading || (in_done && !in_zero);
    if (fading_eff && (fade_cur != 10'd0)) begin
      if ({1'b0, fade_cur} >= fade_rate_q) begin
        fade_level_d = fade_cur - fade_rate_q[9:0];
      end else begin
        fade_level_d = 10'd0;
      end
    end else begin
      fade_level_d = fade_cur;
    end

    if (in_period < PERIOD_MIN) begin
      period_clamp = PERIOD_MIN;
    end else if (in_period > PERIOD_MAX) begin
      period_clamp = PERIOD_MAX;
    end else begin
      period_clamp = in_period;
    end

    sweep_base = ((in_kick == KICK_NEW) || (in_kick == KICK_OFF)) ? 16'd0 : vib_sweep_q;
    sweep_grow = (sweep_base[15:8] < vib_depth_q);
    sweep_sum  = sweep_base + {8'd0, vib_sweep_speed_q};
    vib_sweep_d = sweep_grow ? sweep_sum : sweep_base;
    depth_t     = sweep_grow ? sweep_sum : {vib_depth_q, 8'd0};

    ramp     = {~vib_phase_q[7], vib_phase_q[6:1]};
    sine_mag = {1'b0, SINE_TAB[vib_phase_q[6:0]]};
    case (vib_waveform_q)
      WAVE_SINE:   wave = vib_phase_q[7] ? (8'd0 - sine_mag) : sine_mag;
      WAVE_SQUARE: wave = vib_phase_q[7] ? 8'hC0 : 8'h40;
      WAVE_RAMPDN: wave = 8'd63 - {1'b0, ramp};
      default:     wave = {1'b0, ramp} - 8'd64;
    endcase
    if (vib_depth_q == 8'd0) begin
      wave = 8'd0;
    end
  end

  // Shared multiplier and its operand select
  logic signed [43:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [53:0] mul_p;
  logic signed [10:0] pan_diff, pan_dist, pan_span;

  always_comb begin
    pan_diff = $signed({1'b0, pan_pos_q}) - $signed({1'b0, PAN_CENTRE});
    pan_dist = pan_diff[10] ? -pan_diff : pan_diff;
    pan_span = $signed({1'b0, PAN_CENTRE}) - pan_dist;
    case (step_q)
      STEP_FADE_CHAN: begin
        mul_a = $signed({34'd0, fade_cur_q});
        mul_b = $signed({3'd0, chan_q});
      end
      STEP_NOTE: begin
        mul_a = $signed({1'b0, acc_q[42:0]});
        mul_b = $signed({1'b0, notev_q});
      end
      STEP_MIX: begin
        mul_a = $signed({1'b0, acc_q[42:0]});
        mul_b = $signed({2'd0, mix_level_q});
      end
      STEP_GLOBAL: begin
        mul_a = $signed({1'b0, acc_q[42:0]});
        mul_b = $signed({2'd0, global_level_q});
      end
      STEP_ENV: begin
        mul_a = $signed({1'b0, acc_q[42:0]});
        mul_b = $signed({3'd0, venv_q});
      end
      STEP_PAN: begin
        mul_a = 44'(pan_span);
        mul_b = 10'($signed(pan_env_q));
      end
      default: begin
        mul_a = $signed({28'd0, depth_t_q});
        mul_b = 10'($signed(wave_q));
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Sequencer
  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CALC;
      ST_CALC: if (step_q == STEP_VIB) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_FADE_CHAN;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CALC) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= STEP_FADE_CHAN;
      end
    end
  end

  // Configuration and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vib_depth_q       <= 8'd0;
      vib_sweep_speed_q <= 8'd0;
      vib_rate_q        <= 8'd0;
      vib_waveform_q    <= WAVE_SINE;
      fade_rate_q       <= 11'd0;
      stereo_on_q       <= 1'b1;
      mix_level_q       <= 8'd128;
      global_level_q    <= 8'd128;
      fade_level_q      <= 10'd0;
      vib_phase_q       <= 8'd0;
      vib_sweep_q       <= 16'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (tvm_reg_e'(cfg_addr_i))
          REG_VIB_DEPTH:    vib_depth_q       <= cfg_data_i[7:0];
          REG_VIB_SWEEP:    vib_sweep_speed_q <= cfg_data_i[7:0];
          REG_VIB_RATE:     vib_rate_q        <= cfg_data_i[7:0];
          REG_VIB_WAVEFORM: vib_waveform_q    <= cfg_data_i[1:0];
          REG_FADE_RATE:    fade_rate_q       <= cfg_data_i;
          REG_STEREO_ON:    stereo_on_q       <= cfg_data_i[0];
          REG_MIX_LEVEL:    mix_level_q       <= cfg_data_i[7:0];
          REG_GLOBAL_LEVEL: global_level_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      // A gone voice leaves the state untouched
      if (in_fire && !in_gone) begin
        fade_level_q <= fade_level_d;
        vib_phase_q  <= vib_phase_q + vib_rate_q;
        vib_sweep_q  <= vib_sweep_d;
      end
    end
  end

  // Capture and work registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fade_cur_q <= fade_cur;
      chan_q     <= in_chan;
      notev_q    <= in_notev;
      venv_q     <= in_venv;
      pan_pos_q  <= in_pan_pos;
      pan_env_q  <= in_pan_env;
      period_q   <= period_clamp;
      muted_q    <= in_muted;
      dead_q     <= in_gone || (fade_cur == 10'd0);
      depth_t_q  <= depth_t;
      wave_q     <= wave;
    end
    if (state_q == ST_CALC) begin
      case (step_q)
        STEP_NOTE: begin
          acc_q <= mul_p[48:0];
          // (vol / 16384) * 16, saturated
          svol_q <= (mul_p[25:24] != 2'd0) ? SVOL_MAX : {mul_p[23:14], 4'd0};
        end
        STEP_ENV: begin
          acc_q  <= mul_p[48:0];
          mixv_q <= (mul_p[48:44] != 5'd0) ? MIXV_MAX : mul_p[43:28];
        end
        STEP_PAN: pan_mul_q <= mul_p[17:0];
        STEP_VIB: vib_off_q <= mul_p[23:16];
        default:  acc_q <= mul_p[48:0];
      endcase
    end
  end

  // Result assembly
  logic signed [17:0] pan_round;
  logic signed [12:0] pan_mod;
  logic signed [13:0] pan_sum;
  logic [9:0]         pan_res;
  logic signed [16:0] period_res;
  logic [15:0]        mixv_res;

  always_comb begin
    // Divide by 32 toward zero
    pan_round = $signed(pan_mul_q) + (pan_mul_q[17] ? 18'sd31 : 18'sd0);
    pan_mod   = 13'(pan_round >>> 5);
    pan_sum   = $signed({4'd0, pan_pos_q}) + 14'(pan_mod);
    if (!stereo_on_q) begin
      pan_res = PAN_CENTRE;
    end else if (pan_pos_q == PAN_SURR) begin
      pan_res = PAN_SURR;
    end else if (pan_sum < 14'sd0) begin
      pan_res = 10'd0;
    end else if (pan_sum > 14'sd255) begin
      pan_res = 10'd255;
    end else begin
      pan_res = pan_sum[9:0];
    end
    period_res = $signed({1'b0, period_q}) - 17'($signed(vib_off_q));
    mixv_res   = muted_q ? 16'd0 : mixv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      m_dead_q <= dead_q;
      if (dead_q) begin
        m_data_q <= 64'd0;
      end else begin
        m_data_q <= {7'd0, period_res, pan_res, svol_q, mixv_res};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_dead_q;

`ifndef ASSERT_OFF
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted again right after an accept");

  a_dead_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
    else $error("dead result carries a nonzero payload");

  a_fade_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_level_q <= FADE_START)
    else $error("fade level above its start value");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tvm_pkg::*;

  localparam logic [1:0] KICK_NONE = 2'd0;
  localparam logic [1:0] KICK_ENV  = 2'd2;
  // Index past the register map; the block must drop it
  localparam logic [3:0] REG_UNMAPPED = 4'd12;
  localparam int         HOLD_CYCLES  = 400;

  // Packed so that the struct is the tdata word, period in the low bits
  typedef struct packed {
    logic [2:0]        pad;
    logic              gone;
    logic              muted;
    logic              fading;
    logic signed [6:0] pan_env;
    logic [9:0]        pan_pos;
    logic              env_zero;
    logic              env_done;
    logic [6:0]        env_level;
    logic [8:0]        note_vol;
    logic [6:0]        chan_vol;
    logic [15:0]       period;
  } voice_ctl_t;

  typedef struct packed {
    logic [1:0] kick;
    voice_ctl_t ctl;
  } voice_tick_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic signed [16:0] period;
    logic [9:0]         pan;
    logic [13:0]        svol;
    logic [15:0]        mix;
  } voice_mix_t;

  typedef struct packed {
    logic       dead;
    voice_mix_t bus;
  } voice_result_t;

  typedef struct packed {
    logic [3:0]  addr;
    logic [10:0] value;
  } reg_write_t;

  class tick_modulator_mirror;
    bit [7:0]  depth_r, sweep_step_r, rate_r, mix_r, global_r;
    bit [1:0]  shape_r;
    bit [10:0] fade_step_r;
    bit        stereo_r;
    bit [9:0]  fade;
    bit [7:0]  phase;
    bit [15:0] sweep;
    voice_result_t results_due[$];
    int mismatches, ticks_taken, live_seen, dead_seen, reg_writes;

    function new();
      depth_r = 0; sweep_step_r = 0; rate_r = 0; shape_r = WAVE_SINE;
      fade_step_r = 0; stereo_r = 1'b1; mix_r = 8'd128; global_r = 8'd128;
      fade = 0; phase = 0; sweep = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [10:0] value);
      reg_writes++;
      case (addr)
        REG_VIB_DEPTH:    depth_r = value[7:0];
        REG_VIB_SWEEP:    sweep_step_r = value[7:0];
        REG_VIB_RATE:     rate_r = value[7:0];
        REG_VIB_WAVEFORM: shape_r = value[1:0];
        REG_FADE_RATE:    fade_step_r = value;
        REG_STEREO_ON:    stereo_r = value[0];
        REG_MIX_LEVEL:    mix_r = value[7:0];
        REG_GLOBAL_LEVEL: global_r = value[7:0];
        default: ;
      endcase
    endfunction

    function void accept_tick(voice_tick_t t);
      voice_result_t r;
      longint unsigned vol, svol;
      int per, pan, span, wave, depth_t, ramp;
      bit fading;
      r = '0;
      r.dead = 1'b1;
      ticks_taken++;
      if (!t.ctl.gone) begin
        per = int'(t.ctl.period);
        if (per < int'(PERIOD_MIN)) per = int'(PERIOD_MIN);
        else if (per > int'(PERIOD_MAX)) per = int'(PERIOD_MAX);
        if (t.kick == KICK_NEW || t.kick == KICK_OFF) begin
          fade = FADE_START;
          sweep = 0;
        end
        fading = t.ctl.fading;
        if (t.ctl.env_done) begin
          if (t.ctl.env_zero) fade = 0;
          else fading = 1'b1;
        end

        vol = 64'(fade) * 64'(t.ctl.chan_vol) * 64'(t.ctl.note_vol);
        svol = (vol >> 14) << 4;
        if (svol > 64'(SVOL_MAX)) svol = 64'(SVOL_MAX);
        vol = (vol * 64'(mix_r) * 64'(global_r) * 64'(t.ctl.env_level)) >> 28;
        if (vol > 64'(MIXV_MAX)) vol = 64'(MIXV_MAX);
        if (t.ctl.muted) vol = 0;

        if (!stereo_r) begin
          pan = int'(PAN_CENTRE);
        end else if (t.ctl.pan_pos == PAN_SURR) begin
          pan = int'(PAN_SURR);
        end else begin
          span = int'(t.ctl.pan_pos) - int'(PAN_CENTRE);
          if (span < 0) span = -span;
          pan = int'(t.ctl.pan_pos) +
                (int'(t.ctl.pan_env) * (int'(PAN_CENTRE) - span)) / 32;
          if (pan < 0) pan = 0;
          else if (pan > 255) pan = 255;
        end

        // Ramps run off the phase shifted by half a period
        ramp = int'({~phase[7], phase[6:1]});
        wave = 0;
        if (depth_r != 0) begin
          case (shape_r)
            WAVE_SINE: begin
              wave = int'(SINE_TAB[phase[6:0]]);
              if (phase[7]) wave = -wave;
            end
            WAVE_SQUARE: wave = phase[7] ? -64 : 64;
            WAVE_RAMPDN: wave = 63 - ramp;
            WAVE_RAMPUP: wave = ramp - 64;
            default:     wave = 0;
          endcase
        end
        if ((sweep >> 8) < 16'(depth_r)) begin
          sweep = sweep + 16'(sweep_step_r);
          depth_t = int'(sweep);
        end else begin
          depth_t = int'(depth_r) << 8;
        end
        per = per - ((wave * depth_t) >>> 16);
        phase = phase + rate_r;

        if (fade != 0) begin
          if (fading) fade = (11'(fade) >= fade_step_r) ? 10'(11'(fade) - fade_step_r) : '0;
          r.dead = 1'b0;
          r.bus.mix = vol[15:0];
          r.bus.svol = svol[13:0];
          r.bus.pan = 10'(pan);
          r.bus.period = 17'(per);
        end
      end
      results_due.push_back(r);
    endfunction

    function void take_result(logic [63:0] data, logic dead);
      voice_mix_t got;
      voice_result_t want;
      got = data;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: dead %0b mix %0d svol %0d pan %0d period %0d",
                   dead, got.mix, got.svol, got.pan, got.period);
        return;
      end
      want = results_due.pop_front();
      if (dead) dead_seen++;
      else live_seen++;
      if (dead !== want.dead || got.mix !== want.bus.mix || got.svol !== want.bus.svol ||
          got.pan !== want.bus.pan || got.period !== want.bus.period) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch (expected/actual): dead %0b/%0b mix %0d/%0d svol %0d/%0d",
                 want.dead, dead, want.bus.mix, got.mix, want.bus.svol, got.svol);
          $display(" pan %0d/%0d period %0d/%0d",
                   want.bus.pan, got.pan, want.bus.period, got.period);
        end
      end
    endfunction

    function int owed();
      return results_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_addr_i = '0;
  logic [10:0] cfg_data_i = '0;

  tick_modulator_mirror mirror;
  voice_tick_t tick_q[$];
  reg_write_t  reg_q[$];
  int src_idle_pct = 19;
  int sink_idle_pct = 83;
  logic hold_req = 1'b0;
  logic sink_block = 1'b0;
  int settings = 0;

  tracker_voice_tick_modulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: check each result transaction, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.take_result(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= !sink_block && ($urandom_range(99) >= sink_idle_pct);
  end

  // Long receiver hold so the block backs up and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    sink_block <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_block <= 1'b0;
  end

  function automatic voice_tick_t voice_tick(logic [1:0] kick, bit fading, bit wild);
    voice_tick_t t;
    t = '0;
    t.kick = kick;
    t.ctl.period = (wild || $urandom_range(9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(40, 50000));
    t.ctl.chan_vol = wild ? 7'($urandom) : 7'($urandom_range(64));
    t.ctl.note_vol = wild ? 9'($urandom) : 9'($urandom_range(256));
    t.ctl.env_level = wild ? 7'($urandom)
                           : ($urandom_range(3) == 0) ? 7'd64 : 7'($urandom_range(64));
    t.ctl.env_done = wild ? 1'($urandom) : ($urandom_range(29) == 0);
    t.ctl.env_zero = 1'($urandom);
    t.ctl.pan_pos = wild ? 10'($urandom)
                         : ($urandom_range(7) == 0) ? PAN_SURR : 10'($urandom_range(255));
    t.ctl.pan_env = wild ? 7'($urandom) : 7'(int'($urandom_range(64)) - 32);
    t.ctl.fading = wild ? 1'($urandom) : fading;
    t.ctl.muted = wild ? 1'($urandom) : ($urandom_range(9) == 0);
    t.ctl.gone = wild ? 1'($urandom) : ($urandom_range(39) == 0);
    return t;
  endfunction

  // Mostly note-on or note-off kicks followed by a run of ticks with no kick or an envelope kick
  function automatic void plan_voices(int count);
    int made, len;
    bit fades;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        tick_q.push_back(voice_tick(2'($urandom), 1'b0, 1'b1));
        made++;
      end else begin
        len = $urandom_range(3, 14);
        fades = ($urandom_range(2) == 0);
        tick_q.push_back(voice_tick($urandom_range(1) ? KICK_NEW : KICK_OFF, fades, 1'b0));
        for (int i = 1; i < len; i++)
          tick_q.push_back(voice_tick(($urandom_range(9) == 0) ? KICK_ENV : KICK_NONE,
                                      fades, 1'b0));
        made += len;
      end
    end
  endfunction

  function automatic void plan_regs(int depth, int sweep, int rate, int shape, int fade,
                                    int stereo, int mix, int glob);
    reg_q.push_back('{REG_VIB_DEPTH, 11'(depth)});
    reg_q.push_back('{REG_VIB_SWEEP, 11'(sweep)});
    reg_q.push_back('{REG_VIB_RATE, 11'(rate)});
    reg_q.push_back('{REG_VIB_WAVEFORM, 11'(shape)});
    reg_q.push_back('{REG_FADE_RATE, 11'(fade)});
    reg_q.push_back('{REG_STEREO_ON, 11'(stereo)});
    reg_q.push_back('{REG_MIX_LEVEL, 11'(mix)});
    reg_q.push_back('{REG_GLOBAL_LEVEL, 11'(glob)});
    settings++;
  endfunction

  task automatic apply_regs();
    reg_write_t w;
    while (reg_q.size() > 0) begin
      w = reg_q.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_addr_i <= w.addr;
      cfg_data_i <= w.value;
      do @(posedge clk_i); while (!cfg_ready_o);
      mirror.write_reg(w.addr, w.value);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Keep tvalid high between back-to-back items; drop it only for a gap
  task automatic drain_ticks();
    voice_tick_t t;
    while (tick_q.size() > 0) begin
      t = tick_q.pop_front();
      if ($urandom_range(99) < src_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= t.ctl;
      s_axis_tuser <= t.kick;
      do @(posedge clk_i); while (!s_axis_tready);
      mirror.accept_tick(t);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (mirror.owed() != 0) @(posedge clk_i);
  endtask

  initial begin
    voice_tick_t t;
    mirror = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: no vibrato, stereo on, mix and global level 128
    tick_q.push_back(voice_tick(KICK_NONE, 1'b0, 1'b0));          // still faded out
    t = voice_tick(KICK_NEW, 1'b0, 1'b0); t.ctl.gone = 1'b1;       // gone voice ignores kick
    tick_q.push_back(t);
    t = voice_tick(KICK_NEW, 1'b0, 1'b0);
    t.ctl.gone = 1'b0; t.ctl.env_done = 1'b0; t.ctl.period = 16'd0;
    t.ctl.chan_vol = 7'd64; t.ctl.note_vol = 9'd256; t.ctl.env_level = 7'd64;
    t.ctl.pan_pos = 10'd0; t.ctl.pan_env = 7'sd32; t.ctl.muted = 1'b0;
    tick_q.push_back(t);
    t.kick = KICK_NONE; t.ctl.period = 16'hFFFF; t.ctl.pan_pos = PAN_SURR;
    tick_q.push_back(t);
    t.kick = KICK_ENV; t.ctl.period = 16'd39; t.ctl.pan_pos = 10'd255; t.ctl.pan_env = -7'sd32;
    tick_q.push_back(t);
    // Oversized factors saturate both volumes
    t.kick = KICK_NONE; t.ctl.period = 16'd50001; t.ctl.chan_vol = 7'h7F;
    t.ctl.note_vol = 9'h1FF; t.ctl.env_level = 7'h7F; t.ctl.pan_pos = 10'h3FF;
    t.ctl.pan_env = -7'sd64;
    tick_q.push_back(t);
    t.ctl.muted = 1'b1; t.ctl.pan_pos = 10'd128; t.ctl.pan_env = 7'sd63;
    tick_q.push_back(t);
    t.ctl.muted = 1'b0; t.ctl.env_done = 1'b1; t.ctl.env_zero = 1'b0;
    tick_q.push_back(t);
    t.ctl.env_zero = 1'b1;                                          // envelope kills the voice
    tick_q.push_back(t);
    t.ctl.env_done = 1'b0;
    tick_q.push_back(t);
    t.kick = KICK_OFF;
    tick_q.push_back(t);
    drain_ticks();
    settle();

    // Vibrato sweep, ramp down, forced centre pan and fade underflow
    reg_q.push_back('{REG_UNMAPPED, 11'h7FF});
    plan_regs(255, 255, 200, WAVE_RAMPDN, 100, 0, 255, 255);
    apply_regs();
    t = voice_tick(KICK_NEW, 1'b1, 1'b0);
    t.ctl.gone = 1'b0; t.ctl.env_done = 1'b0; t.ctl.period = 16'd40;
    tick_q.push_back(t);
    t.kick = KICK_NONE;
    for (int i = 0; i < 6; i++) begin
      t.ctl.period = (i % 2 == 0) ? 16'd40 : 16'd50000;
      tick_q.push_back(t);
    end
    t.kick = KICK_ENV;
    tick_q.push_back(t);
    drain_ticks();
    settle();

    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        src_idle_pct = 83;
        sink_idle_pct <= 19;
      end else if (p == 7) begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      case (p)
        1: plan_regs(255, 255, 255, p % 4, 2047, 1, 255, 255);
        2: plan_regs(0, 0, 0, p % 4, 0, 0, 0, 0);
        default:
          plan_regs(($urandom_range(3) == 0) ? 0 : $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), p % 4,
                    ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(40),
                    $urandom_range(4) != 0,
                    ($urandom_range(7) == 0) ? 255 : $urandom_range(128),
                    ($urandom_range(7) == 0) ? 255 : $urandom_range(128));
      endcase
      apply_regs();
      plan_voices(175);
      if (p == 8) hold_req <= 1'b1;
      drain_ticks();
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d ticks: %0d live and %0d dead voices, %0d register settings",
             mirror.ticks_taken, mirror.live_seen, mirror.dead_seen, settings);
    $display("traffic: both idle mixes, full rate and one %0d-cycle output hold; %0d mismatches",
             HOLD_CYCLES, mirror.mismatches);
    if (mirror.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tvm_pkg.sv
rtl/core/tracker_voice_tick_modulator.sv
sim/testbench.sv
